/* hdl/tsrl_pkg.sv */
// Shared types and constants of the timestamp run-length table.
`default_nettype none
package tsrl_pkg;

   localparam int TS_W = 64;
   localparam int DELTA_W = 32;
   localparam int PACK_W = 16;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_BAD = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic [DELTA_W-1:0] count;
      logic [DELTA_W-1:0] delta;
   } run_entry_type;

endpackage
`default_nettype wire

/* hdl/tsrl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tsrl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/tsrl_div.sv */
// Restoring divider, one quotient bit per cycle, for a timestamp by a run count.
`default_nettype none
module tsrl_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tsrl_pkg::TS_W-1:0]      dividend,
   input  wire logic [tsrl_pkg::DELTA_W-1:0]   divisor,
   output logic                                done,
   output logic      [tsrl_pkg::TS_W-1:0]      quotient
);

   localparam int CW = $clog2(tsrl_pkg::TS_W);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [tsrl_pkg::DELTA_W-1:0]  rem_ff, rem_in;
   logic [tsrl_pkg::TS_W-1:0]     quo_ff, quo_in;
   logic [tsrl_pkg::DELTA_W:0]    shifted;
   logic [tsrl_pkg::DELTA_W:0]    diff;
   logic                          ge;

   assign shifted = {rem_ff, quo_ff[tsrl_pkg::TS_W-1]};
   assign ge = shifted >= {1'b0, divisor};
   assign diff = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[tsrl_pkg::DELTA_W-1:0] : shifted[tsrl_pkg::DELTA_W-1:0];
         quo_in = {quo_ff[tsrl_pkg::TS_W-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(tsrl_pkg::TS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* hdl/timestamp_run_length_table.sv */
// Top level: run-length table of decode timestamps with its sequencer.
//
//  Channel   Ports    Direction  Contents of one beat
//  request   req_*    in         action, dts, pack_count, default_duration, entry_index
//  response  rsp_*    out        status, sample_number, entry_total, entry_samples, entry_delta
//
// A read waits in S_RD_WAIT on the registered run memory; an in-order append first loads the
// last two runs, and a split of the last run adds a state for each new run it writes. An append
// that must resolve a packed run's delta waits on the bit-serial divider. An earlier timestamp
// reads each run and unpacks its samples, then makes two passes over the unpacked timestamps
// memory (one entry a cycle) to count and rewrite the runs. Reset is synchronous; the memories
// need no clearing pass. A stalled response beat is held in its output register while the next
// request is accepted.
`default_nettype none
module timestamp_run_length_table #(
   parameter int MAX_RUNS = 256,
   parameter int MAX_SAMPLES = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [63:0] req_dts,
   input  wire logic [15:0] req_pack_count,
   input  wire logic [31:0] req_default_duration,
   input  wire logic [7:0]  req_entry_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [12:0]      rsp_sample_number,
   output logic [8:0]       rsp_entry_total,
   output logic [31:0]      rsp_entry_samples,
   output logic [31:0]      rsp_entry_delta
);

   localparam int RW = $clog2(MAX_RUNS);
   localparam int RUW = $clog2(MAX_RUNS + 1);
   localparam int AW = $clog2(MAX_SAMPLES);
   localparam int SW = $clog2(MAX_SAMPLES + 2);
   localparam int TW = tsrl_pkg::TS_W;
   localparam int DW = tsrl_pkg::DELTA_W;
   localparam int PW = tsrl_pkg::PACK_W;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RD_WAIT = 5'd1;
   localparam logic [4:0] S_AP_LD1 = 5'd2;
   localparam logic [4:0] S_AP_LD2 = 5'd3;
   localparam logic [4:0] S_DIV_WAIT = 5'd4;
   localparam logic [4:0] S_DIV_LT = 5'd5;
   localparam logic [4:0] S_AP_SUM = 5'd6;
   localparam logic [4:0] S_AP_EVAL = 5'd7;
   localparam logic [4:0] S_SPL1 = 5'd8;
   localparam logic [4:0] S_SPL2 = 5'd9;
   localparam logic [4:0] S_U_RD = 5'd10;
   localparam logic [4:0] S_U_LD = 5'd11;
   localparam logic [4:0] S_U_EMIT = 5'd12;
   localparam logic [4:0] S_R_RUN = 5'd13;
   localparam logic [4:0] S_R_FIN = 5'd14;
   localparam logic [4:0] S_RESP = 5'd15;

   // Control state.
   logic [4:0]    state_ff, state_in;
   logic [RUW-1:0] runs_used_ff, runs_used_in;
   logic [TW-1:0] last_ts_ff, last_ts_in;
   logic [SW-1:0] samples_ff, samples_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // Working registers.
   logic [TW-1:0] dts_ff, dts_in;
   logic [PW-1:0] pack_ff, pack_in;
   logic [DW-1:0] c_ff, c_in, d_ff, d_in, c2_ff, c2_in, d2_ff, d2_in;
   logic [TW-1:0] lt_ff, lt_in, sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic [DW-1:0] diff_ff, diff_in, mul_ff, mul_in;
   logic [RUW-1:0] ui_ff, ui_in;
   logic [DW-1:0] ucnt_ff, ucnt_in, udlt_ff, udlt_in, uk_ff, uk_in;
   logic [TW-1:0] ut_ff, ut_in, prev_ff, prev_in;
   logic [SW-1:0] uidx_ff, uidx_in, pos_ff, pos_in, ra_ff, ra_in, rm_ff, rm_in;
   logic          udone_ff, udone_in, rv_ff, rv_in, pass_ff, pass_in;
   logic [RW-1:0] j_ff, j_in;
   logic [DW-1:0] cur_cnt_ff, cur_cnt_in, cur_dlt_ff, cur_dlt_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [SW-1:0] res_sn_ff, res_sn_in;
   logic [DW-1:0] res_es_ff, res_es_in, res_ed_ff, res_ed_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [12:0]   rsp_sn_ff, rsp_sn_in;
   logic [8:0]    rsp_total_ff, rsp_total_in;
   logic [DW-1:0] rsp_es_ff, rsp_es_in, rsp_ed_ff, rsp_ed_in;

   // Memory ports.
   logic                    run_we;
   logic [RW-1:0]           run_waddr, run_raddr;
   tsrl_pkg::run_entry_type run_wdata, run_rdata;
   logic                    ut_we;
   logic [AW-1:0]           ut_waddr, ut_raddr;
   logic [TW-1:0]           ut_wdata, ut_rdata;

   logic          div_start, div_done;
   logic [TW-1:0] div_quot;

   // Helpers.
   logic [PW-1:0]  req_pack_eff, pack_m1;
   logic [RUW-1:0] n_m1, n_m2, n_p1;
   logic [31:0]    samples32, sum_pack, runs_need;
   logic           full_pack, full_one, full_runs, ext_hit;
   logic [TW-1:0]  dts_lt, rdiff_full;
   logic [47:0]    mul_full;
   logic [DW-1:0]  d_twice;

   assign req_pack_eff = (req_pack_count == '0) ? PW'(1) : req_pack_count;
   assign pack_m1 = pack_ff - PW'(1);
   assign n_m1 = runs_used_ff - RUW'(1);
   assign n_m2 = runs_used_ff - RUW'(2);
   assign n_p1 = runs_used_ff + RUW'(1);
   assign samples32 = 32'(samples_ff);
   assign sum_pack = samples32 + 32'(pack_ff);
   assign full_pack = sum_pack > 32'(MAX_SAMPLES);
   assign full_one = samples32 >= 32'(MAX_SAMPLES);
   assign runs_need = 32'(runs_used_ff) + ((pack_ff == PW'(1)) ? 32'd1 : 32'd2);
   assign full_runs = runs_need > 32'(MAX_RUNS);
   assign ext_hit = (dts_ff == sum1_ff) ||
                    ((pack_ff > PW'(1)) && ((dts_ff == lt_ff) || (dts_ff == sum2_ff)));
   assign dts_lt = dts_ff - lt_ff;
   assign rdiff_full = ut_rdata - prev_ff;
   assign mul_full = {16'd0, d_ff} * {32'd0, pack_m1};
   assign d_twice = {d_ff[DW-2:0], 1'b0};

   always_comb begin
      state_in = state_ff;
      runs_used_in = runs_used_ff;
      last_ts_in = last_ts_ff;
      samples_in = samples_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      dts_in = dts_ff;
      pack_in = pack_ff;
      c_in = c_ff;
      d_in = d_ff;
      c2_in = c2_ff;
      d2_in = d2_ff;
      lt_in = lt_ff;
      sum1_in = sum1_ff;
      sum2_in = sum2_ff;
      diff_in = diff_ff;
      mul_in = mul_ff;
      ui_in = ui_ff;
      ucnt_in = ucnt_ff;
      udlt_in = udlt_ff;
      uk_in = uk_ff;
      ut_in = ut_ff;
      prev_in = prev_ff;
      uidx_in = uidx_ff;
      pos_in = pos_ff;
      ra_in = ra_ff;
      rm_in = rm_ff;
      udone_in = udone_ff;
      rv_in = rv_ff;
      pass_in = pass_ff;
      j_in = j_ff;
      cur_cnt_in = cur_cnt_ff;
      cur_dlt_in = cur_dlt_ff;
      res_status_in = res_status_ff;
      res_sn_in = res_sn_ff;
      res_es_in = res_es_ff;
      res_ed_in = res_ed_ff;
      rsp_status_in = rsp_status_ff;
      rsp_sn_in = rsp_sn_ff;
      rsp_total_in = rsp_total_ff;
      rsp_es_in = rsp_es_ff;
      rsp_ed_in = rsp_ed_ff;
      run_we = 1'b0;
      run_waddr = n_m1[RW-1:0];
      run_wdata = '0;
      run_raddr = n_m1[RW-1:0];
      ut_we = 1'b0;
      ut_waddr = uidx_ff[AW-1:0];
      ut_wdata = dts_ff;
      ut_raddr = ra_ff[AW-1:0];
      div_start = 1'b0;

      case (state_ff)
         S_IDLE: begin
            dts_in = req_dts;
            pack_in = req_pack_eff;
            if (req_action == tsrl_pkg::ACT_READ) begin
               run_raddr = RW'(req_entry_index);
            end
            if (req_valid) begin
               res_status_in = tsrl_pkg::ST_OK;
               res_sn_in = '0;
               res_es_in = '0;
               res_ed_in = '0;
               if (req_action == tsrl_pkg::ACT_READ) begin
                  if (32'(req_entry_index) < 32'(runs_used_ff)) begin
                     state_in = S_RD_WAIT;
                  end else begin
                     res_status_in = tsrl_pkg::ST_BAD;
                     state_in = S_RESP;
                  end
               end else if (runs_used_ff == '0) begin
                  state_in = S_RESP;
                  if (req_dts != '0) begin
                     res_status_in = tsrl_pkg::ST_BAD;
                  end else if (32'(req_pack_eff) > 32'(MAX_SAMPLES)) begin
                     res_status_in = tsrl_pkg::ST_FULL;
                  end else begin
                     run_we = 1'b1;
                     run_waddr = '0;
                     run_wdata.count = 32'(req_pack_eff);
                     run_wdata.delta = (req_pack_eff > PW'(1)) ? '0 : req_default_duration;
                     runs_used_in = RUW'(1);
                     samples_in = SW'(req_pack_eff);
                     res_sn_in = SW'(1);
                  end
               end else if (req_dts < last_ts_ff) begin
                  ui_in = '0;
                  ut_in = '0;
                  uidx_in = '0;
                  pos_in = '0;
                  udone_in = 1'b0;
                  state_in = S_U_RD;
               end else begin
                  state_in = S_AP_LD1;
               end
            end
         end
         S_RD_WAIT: begin
            res_es_in = run_rdata.count;
            res_ed_in = run_rdata.delta;
            state_in = S_RESP;
         end
         S_AP_LD1: begin
            c_in = run_rdata.count;
            d_in = run_rdata.delta;
            run_raddr = n_m2[RW-1:0];
            state_in = S_AP_LD2;
         end
         S_AP_LD2: begin
            c2_in = run_rdata.count;
            d2_in = run_rdata.delta;
            lt_in = last_ts_ff;
            if ((d_ff == '0) && (c_ff > 32'd1)) begin
               div_start = 1'b1;
               state_in = S_DIV_WAIT;
            end else begin
               state_in = S_AP_SUM;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               d_in = div_quot[DW-1:0];
               state_in = S_DIV_LT;
            end
         end
         S_DIV_LT: begin
            lt_in = dts_ff - {32'd0, d_ff};
            state_in = S_AP_SUM;
         end
         S_AP_SUM: begin
            sum1_in = lt_ff + {32'd0, d_ff};
            sum2_in = lt_ff + {32'd0, d_twice};
            diff_in = dts_lt[DW-1:0];
            mul_in = mul_full[DW-1:0];
            state_in = S_AP_EVAL;
         end
         S_AP_EVAL: begin
            state_in = S_RESP;
            if (ext_hit) begin
               if (full_pack) begin
                  res_status_in = tsrl_pkg::ST_FULL;
               end else begin
                  run_we = 1'b1;
                  run_wdata.count = c_ff + 32'(pack_ff);
                  run_wdata.delta = d_ff;
                  res_sn_in = samples_ff + SW'(1);
                  samples_in = SW'(sum_pack);
                  last_ts_in = dts_ff + {32'd0, mul_ff};
               end
            end else if (c_ff == 32'd1) begin
               if (full_one) begin
                  res_status_in = tsrl_pkg::ST_FULL;
               end else begin
                  run_we = 1'b1;
                  if ((runs_used_ff >= RUW'(2)) && (diff_ff == d2_ff)) begin
                     run_waddr = n_m2[RW-1:0];
                     run_wdata.count = c2_ff + 32'd2;
                     run_wdata.delta = d2_ff;
                     runs_used_in = n_m1;
                  end else begin
                     run_wdata.count = 32'd2;
                     run_wdata.delta = diff_ff;
                  end
                  samples_in = samples_ff + SW'(1);
                  res_sn_in = samples_ff + SW'(1);
                  last_ts_in = dts_ff;
               end
            end else if (full_runs || full_pack) begin
               res_status_in = tsrl_pkg::ST_FULL;
            end else begin
               run_we = 1'b1;
               run_wdata.count = c_ff - 32'd1;
               run_wdata.delta = d_ff;
               res_sn_in = samples_ff + SW'(1);
               samples_in = SW'(sum_pack);
               last_ts_in = dts_ff;
               state_in = S_SPL1;
            end
         end
         S_SPL1: begin
            run_we = 1'b1;
            run_waddr = runs_used_ff[RW-1:0];
            run_wdata.delta = diff_ff;
            if (pack_ff == PW'(1)) begin
               run_wdata.count = 32'd2;
               runs_used_in = n_p1;
               state_in = S_RESP;
            end else begin
               run_wdata.count = 32'd1;
               state_in = S_SPL2;
            end
         end
         S_SPL2: begin
            run_we = 1'b1;
            run_waddr = n_p1[RW-1:0];
            run_wdata.count = 32'(pack_ff);
            run_wdata.delta = d_ff;
            runs_used_in = runs_used_ff + RUW'(2);
            state_in = S_RESP;
         end
         S_U_RD: begin
            run_raddr = ui_ff[RW-1:0];
            state_in = S_U_LD;
         end
         S_U_LD: begin
            ucnt_in = run_rdata.count;
            udlt_in = run_rdata.delta;
            uk_in = '0;
            state_in = S_U_EMIT;
         end
         S_U_EMIT: begin
            if (uk_ff == ucnt_ff) begin
               ui_in = ui_ff + RUW'(1);
               if ((ui_ff + RUW'(1)) == runs_used_ff) begin
                  if (!udone_ff) begin
                     res_status_in = tsrl_pkg::ST_BAD;
                     state_in = S_RESP;
                  end else if (full_one) begin
                     res_status_in = tsrl_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     pass_in = 1'b0;
                     ra_in = '0;
                     rv_in = 1'b0;
                     j_in = '0;
                     state_in = S_R_RUN;
                  end
               end else begin
                  state_in = S_U_RD;
               end
            end else if (!udone_ff && (ut_ff > dts_ff)) begin
               ut_we = 32'(uidx_ff) < 32'(MAX_SAMPLES);
               ut_wdata = dts_ff;
               uidx_in = uidx_ff + SW'(1);
               pos_in = uidx_ff + SW'(1);
               udone_in = 1'b1;
            end else begin
               ut_we = 32'(uidx_ff) < 32'(MAX_SAMPLES);
               ut_wdata = ut_ff;
               ut_in = ut_ff + {32'd0, udlt_ff};
               uidx_in = uidx_ff + SW'(1);
               uk_in = uk_ff + 32'd1;
            end
         end
         S_R_RUN: begin
            if (ra_ff <= samples_ff) begin
               ra_in = ra_ff + SW'(1);
               rm_in = ra_ff;
               rv_in = 1'b1;
            end else begin
               rv_in = 1'b0;
            end
            if (rv_ff) begin
               prev_in = ut_rdata;
               if (rm_ff != '0) begin
                  if (rm_ff == samples_ff) begin
                     state_in = S_R_FIN;
                  end
                  if (rm_ff == SW'(1)) begin
                     cur_cnt_in = 32'd1;
                     cur_dlt_in = rdiff_full[DW-1:0];
                  end else if (rdiff_full[DW-1:0] == cur_dlt_ff) begin
                     cur_cnt_in = cur_cnt_ff + 32'd1;
                  end else if (32'(j_ff) == 32'(MAX_RUNS - 1)) begin
                     res_status_in = tsrl_pkg::ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     run_we = pass_ff;
                     run_waddr = j_ff;
                     run_wdata.count = cur_cnt_ff;
                     run_wdata.delta = cur_dlt_ff;
                     j_in = j_ff + RW'(1);
                     cur_cnt_in = 32'd1;
                     cur_dlt_in = rdiff_full[DW-1:0];
                  end
               end
            end
         end
         S_R_FIN: begin
            if (!pass_ff) begin
               pass_in = 1'b1;
               ra_in = '0;
               rv_in = 1'b0;
               j_in = '0;
               state_in = S_R_RUN;
            end else begin
               run_we = 1'b1;
               run_waddr = j_ff;
               run_wdata.count = cur_cnt_ff + 32'd1;
               run_wdata.delta = cur_dlt_ff;
               runs_used_in = RUW'(j_ff) + RUW'(1);
               samples_in = samples_ff + SW'(1);
               res_sn_in = pos_ff;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_sn_in = (res_status_ff == tsrl_pkg::ST_OK) ? 13'(res_sn_ff) : 13'd0;
               rsp_total_in = 9'(runs_used_ff);
               rsp_es_in = res_es_ff;
               rsp_ed_in = res_ed_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         runs_used_ff <= '0;
         last_ts_ff <= '0;
         samples_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         runs_used_ff <= runs_used_in;
         last_ts_ff <= last_ts_in;
         samples_ff <= samples_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dts_ff <= dts_in;
      pack_ff <= pack_in;
      c_ff <= c_in;
      d_ff <= d_in;
      c2_ff <= c2_in;
      d2_ff <= d2_in;
      lt_ff <= lt_in;
      sum1_ff <= sum1_in;
      sum2_ff <= sum2_in;
      diff_ff <= diff_in;
      mul_ff <= mul_in;
      ui_ff <= ui_in;
      ucnt_ff <= ucnt_in;
      udlt_ff <= udlt_in;
      uk_ff <= uk_in;
      ut_ff <= ut_in;
      prev_ff <= prev_in;
      uidx_ff <= uidx_in;
      pos_ff <= pos_in;
      ra_ff <= ra_in;
      rm_ff <= rm_in;
      udone_ff <= udone_in;
      rv_ff <= rv_in;
      pass_ff <= pass_in;
      j_ff <= j_in;
      cur_cnt_ff <= cur_cnt_in;
      cur_dlt_ff <= cur_dlt_in;
      res_status_ff <= res_status_in;
      res_sn_ff <= res_sn_in;
      res_es_ff <= res_es_in;
      res_ed_ff <= res_ed_in;
      rsp_status_ff <= rsp_status_in;
      rsp_sn_ff <= rsp_sn_in;
      rsp_total_ff <= rsp_total_in;
      rsp_es_ff <= rsp_es_in;
      rsp_ed_ff <= rsp_ed_in;
   end

   tsrl_ram #(
      .WIDTH(2 * DW),
      .DEPTH(MAX_RUNS)
   ) u_run_ram (
      .clock   (clock),
      .wr_en   (run_we),
      .wr_addr (run_waddr),
      .wr_data (run_wdata),
      .rd_addr (run_raddr),
      .rd_data (run_rdata)
   );

   tsrl_ram #(
      .WIDTH(TW),
      .DEPTH(MAX_SAMPLES)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (ut_we),
      .wr_addr (ut_waddr),
      .wr_data (ut_wdata),
      .rd_addr (ut_raddr),
      .rd_data (ut_rdata)
   );

   tsrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dts_ff),
      .divisor  (c_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_sample_number = rsp_sn_ff;
   assign rsp_entry_total = rsp_total_ff;
   assign rsp_entry_samples = rsp_es_ff;
   assign rsp_entry_delta = rsp_ed_ff;

   a_samples_bound: assert property (@(posedge clock) disable iff (reset)
      32'(samples_ff) <= 32'(MAX_SAMPLES))
      else $error("sample total above its limit");

   a_runs_match_samples: assert property (@(posedge clock) disable iff (reset)
      (runs_used_ff == '0) == (samples_ff == '0))
      else $error("run count and sample total disagree on an empty table");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start work");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished with no one waiting");

endmodule
`default_nettype wire

/* dv/tb_timestamp_run_length_table.sv */
// Self-checking testbench for the timestamp run-length table with random traffic and stalls.
`default_nettype none
module tb_timestamp_run_length_table;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RUN_CAP = 256;
   localparam int SAMPLE_CAP = 4096;
   localparam int STALL_LIMIT = 50000;
   localparam int HOLD_CYCLES = 300;
   localparam logic ACT_ADD = 1'b0;

   typedef struct {
      logic        action;
      logic [63:0] dts;
      logic [15:0] pack_count;
      logic [31:0] default_duration;
      logic [7:0]  entry_index;
   } request_type;

   typedef struct {
      logic [1:0]  status;
      logic [12:0] sample_number;
      logic [8:0]  entry_total;
      logic [31:0] entry_samples;
      logic [31:0] entry_delta;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_action;
   logic [63:0] req_dts;
   logic [15:0] req_pack_count;
   logic [31:0] req_default_duration;
   logic [7:0]  req_entry_index;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [12:0] rsp_sample_number;
   logic [8:0]  rsp_entry_total;
   logic [31:0] rsp_entry_samples;
   logic [31:0] rsp_entry_delta;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_requests;
   int          hold_served;
   int          hold_left;
   int          stall_cycles;
   int          error_count;

   // Shadow copy of the table.
   logic [31:0] tab_counts[RUN_CAP];
   logic [31:0] tab_deltas[RUN_CAP];
   int          tab_runs;
   logic [63:0] tab_last_ts;
   int          tab_write_sn;
   int          tab_samples;
   logic [63:0] flat_times[SAMPLE_CAP+1];
   logic [31:0] recoded_counts[RUN_CAP];
   logic [31:0] recoded_deltas[RUN_CAP];

   timestamp_run_length_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_dts(req_dts), .req_pack_count(req_pack_count),
      .req_default_duration(req_default_duration), .req_entry_index(req_entry_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_sample_number(rsp_sample_number), .rsp_entry_total(rsp_entry_total),
      .rsp_entry_samples(rsp_entry_samples), .rsp_entry_delta(rsp_entry_delta)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic insert_earlier(input logic [63:0] dts, output logic [1:0] st, output int sn);
      int          total;
      int          pos;
      int          idx;
      int          j;
      logic [63:0] t;
      logic [31:0] d;
      bit          done;
      total = tab_samples;
      pos = 0;
      idx = 0;
      t = 64'd0;
      done = 1'b0;
      sn = 0;
      for (int i = 0; i < tab_runs; i++) begin
         for (int k = 0; k < int'(tab_counts[i]); k++) begin
            if (!done && t > dts) begin
               flat_times[idx] = dts;
               idx++;
               pos = idx;
               done = 1'b1;
            end
            flat_times[idx] = t;
            t = t + {32'd0, tab_deltas[i]};
            idx++;
         end
      end
      if (!done) begin
         st = tsrl_pkg::ST_BAD;
         return;
      end
      if (total + 1 > SAMPLE_CAP || idx != total + 1 || total < 1) begin
         st = tsrl_pkg::ST_FULL;
         return;
      end
      j = 0;
      recoded_counts[0] = 32'd1;
      recoded_deltas[0] = flat_times[1][31:0];
      for (int i = 1; i <= total; i++) begin
         if (i == total) begin
            recoded_counts[j]++;
         end else begin
            d = 32'(flat_times[i+1] - flat_times[i]);
            if (recoded_deltas[j] == d) begin
               recoded_counts[j]++;
            end else begin
               if (j + 1 >= RUN_CAP) begin
                  st = tsrl_pkg::ST_FULL;
                  return;
               end
               j++;
               recoded_counts[j] = 32'd1;
               recoded_deltas[j] = d;
            end
         end
      end
      for (int i = 0; i <= j; i++) begin
         tab_counts[i] = recoded_counts[i];
         tab_deltas[i] = recoded_deltas[i];
      end
      tab_runs = j + 1;
      tab_samples = total + 1;
      tab_write_sn = total + 1;
      sn = pos;
      st = tsrl_pkg::ST_OK;
   endtask

   task automatic append_timestamp(input logic [63:0] dts, input int pack,
                                   input logic [31:0] dflt, output logic [1:0] st,
                                   output int sn);
      int          n;
      logic [31:0] c;
      logic [31:0] d;
      logic [63:0] lt;
      logic [63:0] quot;
      logic [31:0] twice;
      n = tab_runs;
      sn = 0;
      st = tsrl_pkg::ST_OK;
      if (n == 0) begin
         if (dts != 64'd0) begin
            st = tsrl_pkg::ST_BAD;
         end else if (pack > SAMPLE_CAP) begin
            st = tsrl_pkg::ST_FULL;
         end else begin
            tab_counts[0] = 32'(pack);
            tab_deltas[0] = (pack > 1) ? 32'd0 : dflt;
            tab_runs = 1;
            tab_write_sn = pack;
            tab_samples = pack;
            sn = 1;
         end
         return;
      end
      if (dts < tab_last_ts) begin
         insert_earlier(dts, st, sn);
         return;
      end
      c = tab_counts[n-1];
      d = tab_deltas[n-1];
      lt = tab_last_ts;
      if (d == 32'd0 && c > 32'd1) begin
         quot = dts / {32'd0, c};
         d = quot[31:0];
         lt = dts - {32'd0, d};
      end
      twice = d * 32'd2;
      if (dts == lt + {32'd0, d} ||
          (pack > 1 && (dts == lt || dts == lt + {32'd0, twice}))) begin
         if (tab_samples + pack > SAMPLE_CAP) begin
            st = tsrl_pkg::ST_FULL;
            return;
         end
         tab_counts[n-1] = c + 32'(pack);
         tab_deltas[n-1] = d;
         sn = tab_write_sn + 1;
         tab_write_sn += pack;
         tab_samples += pack;
         tab_last_ts = dts + {32'd0, 32'(d * 32'(pack - 1))};
         return;
      end
      if (c == 32'd1) begin
         if (tab_samples + 1 > SAMPLE_CAP) begin
            st = tsrl_pkg::ST_FULL;
            return;
         end
         d = 32'(dts - lt);
         if (n >= 2 && d == tab_deltas[n-2]) begin
            tab_counts[n-2] += 32'd2;
            tab_runs = n - 1;
         end else begin
            tab_counts[n-1] = 32'd2;
            tab_deltas[n-1] = d;
         end
         tab_write_sn++;
         tab_samples++;
         tab_last_ts = dts;
         sn = tab_write_sn;
         return;
      end
      if (n + ((pack == 1) ? 1 : 2) > RUN_CAP || tab_samples + pack > SAMPLE_CAP) begin
         st = tsrl_pkg::ST_FULL;
         return;
      end
      tab_counts[n-1] = c - 32'd1;
      tab_deltas[n-1] = d;
      sn = tab_write_sn + 1;
      if (pack == 1) begin
         tab_counts[n] = 32'd2;
         tab_deltas[n] = 32'(dts - lt);
         tab_runs = n + 1;
      end else begin
         tab_counts[n] = 32'd1;
         tab_deltas[n] = 32'(dts - lt);
         tab_counts[n+1] = 32'(pack);
         tab_deltas[n+1] = d;
         tab_runs = n + 2;
      end
      tab_write_sn += pack;
      tab_samples += pack;
      tab_last_ts = dts;
   endtask

   task automatic predict_answer(input request_type rq, output answer_type an);
      int sn;
      int pack;
      an.sample_number = 13'd0;
      an.entry_samples = 32'd0;
      an.entry_delta = 32'd0;
      if (rq.action == tsrl_pkg::ACT_READ) begin
         if (int'(rq.entry_index) < tab_runs) begin
            an.status = tsrl_pkg::ST_OK;
            an.entry_samples = tab_counts[rq.entry_index];
            an.entry_delta = tab_deltas[rq.entry_index];
         end else begin
            an.status = tsrl_pkg::ST_BAD;
         end
      end else begin
         pack = (rq.pack_count == 16'd0) ? 1 : int'(rq.pack_count);
         append_timestamp(rq.dts, pack, rq.default_duration, an.status, sn);
         if (an.status == tsrl_pkg::ST_OK) an.sample_number = 13'(sn);
      end
      an.entry_total = 9'(tab_runs);
   endtask

   // Request driver.
   always @(posedge clock) begin
      request_type rq;
      answer_type  an;
      bit          fire;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            rq.action = req_action;
            rq.dts = req_dts;
            rq.pack_count = req_pack_count;
            rq.default_duration = req_default_duration;
            rq.entry_index = req_entry_index;
            predict_answer(rq, an);
            expected_answers.push_back(an);
         end
         if (!req_valid || fire) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_action <= rq.action;
               req_dts <= rq.dts;
               req_pack_count <= rq.pack_count;
               req_default_duration <= rq.default_duration;
               req_entry_index <= rq.entry_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response receiver with occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_served <= 0;
      end else if (hold_served < hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      answer_type an;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response beat, status %0d", $time, rsp_status);
            error_count++;
         end else begin
            an = expected_answers.pop_front();
            if (rsp_status !== an.status) begin
               $display("%0t: status expected %0d actual %0d", $time, an.status, rsp_status);
               error_count++;
            end
            if (rsp_sample_number !== an.sample_number) begin
               $display("%0t: sample_number expected %0d actual %0d", $time,
                        an.sample_number, rsp_sample_number);
               error_count++;
            end
            if (rsp_entry_total !== an.entry_total) begin
               $display("%0t: entry_total expected %0d actual %0d", $time,
                        an.entry_total, rsp_entry_total);
               error_count++;
            end
            if (rsp_entry_samples !== an.entry_samples) begin
               $display("%0t: entry_samples expected %0d actual %0d", $time,
                        an.entry_samples, rsp_entry_samples);
               error_count++;
            end
            if (rsp_entry_delta !== an.entry_delta) begin
               $display("%0t: entry_delta expected %0d actual %0d", $time,
                        an.entry_delta, rsp_entry_delta);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any accepted beat.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   logic [63:0] gen_ts;
   logic [31:0] gen_delta;

   task automatic queue_request(input logic act, input logic [63:0] dts, input logic [15:0] pk,
                                input logic [31:0] dflt, input logic [7:0] ix);
      request_type rq;
      rq.action = act;
      rq.dts = dts;
      rq.pack_count = pk;
      rq.default_duration = dflt;
      rq.entry_index = ix;
      pending_requests.push_back(rq);
   endtask

   task automatic queue_random_request();
      int          sel;
      int          pk;
      logic [63:0] r64;
      logic [63:0] dts;
      logic [31:0] step;
      sel = $urandom_range(99);
      r64 = {$urandom, $urandom};
      if (sel < 15) begin
         queue_request(tsrl_pkg::ACT_READ, r64, 16'($urandom),  $urandom,
                       (sel < 3) ? 8'($urandom) : 8'($urandom_range(40)));
         return;
      end
      if (sel < 18) begin
         queue_request(1'b0 ^ ACT_ADD, (gen_ts == 0) ? 64'd0 : r64 % gen_ts,
                       16'($urandom_range(3)), $urandom, 8'($urandom));
         return;
      end
      sel = $urandom_range(99);
      if (sel < 75) pk = $urandom_range(1);
      else if (sel < 95) pk = $urandom_range(8, 2);
      else pk = $urandom_range(65535);
      sel = $urandom_range(99);
      if (sel < 70) begin
         step = gen_delta;
      end else if (sel < 85) begin
         step = $urandom_range(1000, 1);
         gen_delta = step;
      end else if (sel < 90) begin
         step = gen_delta * 32'd2;
      end else if (sel < 95) begin
         step = 32'd0;
      end else begin
         step = $urandom;
         gen_delta = step;
      end
      dts = gen_ts + {32'd0, step};
      gen_ts = dts + {32'd0, 32'(gen_delta * 32'((pk == 0) ? 0 : pk - 1))};
      queue_request(ACT_ADD, dts, 16'(pk), $urandom, 8'($urandom));
   endtask

   task automatic wait_drained();
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ADD;
      req_dts = 64'd0;
      req_pack_count = 16'd0;
      req_default_duration = 32'd0;
      req_entry_index = 8'd0;
      rsp_ready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      error_count = 0;
      tab_runs = 0;
      tab_last_ts = 64'd0;
      tab_write_sn = 0;
      tab_samples = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty reads, bad first stamp, division, extend, split, merge, insertion.
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd0);
      queue_request(tsrl_pkg::ACT_READ, '1, '1, '1, 8'd255);
      queue_request(ACT_ADD, 64'd5, 16'd1, 32'd10, 8'd0);
      queue_request(ACT_ADD, '1, 16'd1, 32'd10, 8'd0);
      queue_request(ACT_ADD, 64'd0, 16'd3, '1, 8'd0);
      queue_request(ACT_ADD, 64'd300, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd400, 16'd0, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd450, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd500, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd550, 16'd2, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd700, 16'd3, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd1000, 16'd2, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd1007, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd1014, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd120, 16'd9, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd0, 16'd1, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd1020, 16'd65535, 32'd0, 8'd0);
      queue_request(ACT_ADD, 64'd1020, 16'hFFFF, 32'd0, 8'd0);
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd0);
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd1);
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd2);
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd3);
      queue_request(tsrl_pkg::ACT_READ, 64'd0, 16'd0, 32'd0, 8'd200);
      gen_ts = 64'd1020;
      gen_delta = 32'd7;
      wait_drained();

      send_idle_pct = 10;
      recv_idle_pct = 80;
      for (int i = 0; i < 200; i++) queue_random_request();
      while (pending_requests.size() > 150) @(posedge clock);
      hold_requests = 1;
      for (int i = 0; i < 230; i++) queue_random_request();
      wait_drained();

      send_idle_pct = 80;
      recv_idle_pct = 10;
      for (int i = 0; i < 430; i++) queue_random_request();
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 400; i++) queue_random_request();
      for (int i = 0; i < 20; i++)
         queue_request(1'($urandom), {$urandom, $urandom}, 16'($urandom), $urandom,
                       8'($urandom));
      queue_request(ACT_ADD, '1, 16'd1, 32'd0, 8'd0);
      wait_drained();
      repeat (20) @(posedge clock);

      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* sim.f */
hdl/tsrl_pkg.sv
hdl/tsrl_ram.sv
hdl/tsrl_div.sv
hdl/timestamp_run_length_table.sv
dv/tb_timestamp_run_length_table.sv
